// ===== sv/wsd_pkg.sv =====
package wsd_pkg;
    localparam int MaxNodes   = 64;
    localparam int CoordBits  = 16;
    localparam int IdxW       = $clog2(MaxNodes);
    localparam int CntW       = $clog2(MaxNodes + 1);
    localparam int DistW      = 33;

    localparam logic       CMD_ADD   = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;
    localparam logic [1:0] ST_DIST   = 2'd0;
    localparam logic [1:0] ST_ADDED  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic        command;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [DistW-1:0] sq_distance;
        logic [5:0]       rank;
        logic             last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch pixel
        logic add_node;   // write node table at count
        logic rd_node;    // issue node read at scan index
        logic calc;       // node data valid: form distance
        logic ins;        // insert distance into sorted row
        logic clr_row;    // empty the sorted row
        logic shift_out;  // pop head of sorted row
    } t_cmd;

    typedef struct packed {
        logic [CntW-1:0] total;
    } t_sts;
endpackage

// ===== sv/wsd_ram.sv =====
module wsd_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/wsd_datapath.sv =====
module wsd_datapath import wsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in              i_item,
    input  logic [IdxW-1:0]  i_scan_idx,
    output t_sts             o_sts,
    output logic [DistW-1:0] o_head
);
    logic [CntW-1:0]      r_total;
    logic [CoordBits-1:0] r_px, r_py;
    logic [CoordBits-1:0] w_nx, w_ny;
    logic [CoordBits-1:0] r_dx, r_dy;
    logic [DistW-1:0]     r_d;
    // sorted row: each slot compares with the new value in parallel,
    // a parallel compare-and-shift insertion (one slot per node)
    logic [DistW-1:0]     r_row [MaxNodes];
    logic [MaxNodes-1:0]  r_used;

    wsd_ram #(.Width(CoordBits), .Depth(MaxNodes)) u_xram (
        .i_clk(i_clk), .i_we(i_cmd.add_node), .i_waddr(r_total[IdxW-1:0]),
        .i_wdata(i_item.coord_x[CoordBits-1:0]), .i_raddr(i_scan_idx),
        .o_rdata(w_nx));
    wsd_ram #(.Width(CoordBits), .Depth(MaxNodes)) u_yram (
        .i_clk(i_clk), .i_we(i_cmd.add_node), .i_waddr(r_total[IdxW-1:0]),
        .i_wdata(i_item.coord_y[CoordBits-1:0]), .i_raddr(i_scan_idx),
        .o_rdata(w_ny));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.add_node) begin
            r_total <= r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_item.coord_x[CoordBits-1:0];
            r_py <= i_item.coord_y[CoordBits-1:0];
        end
        if (i_cmd.calc) begin
            r_dx <= (w_nx >= r_px) ? w_nx - r_px : r_px - w_nx;
            r_dy <= (w_ny >= r_py) ? w_ny - r_py : r_py - w_ny;
        end
        // full 32-bit squares, 33-bit sum
        r_d <= DistW'(32'(r_dx) * 32'(r_dx)) + DistW'(32'(r_dy) * 32'(r_dy));
    end

    // slot k takes new value if it is first slot greater than d (or free)
    logic [MaxNodes-1:0] w_gt;
    always_comb begin
        for (int k = 0; k < MaxNodes; k++) begin
            w_gt[k] = !r_used[k] || (r_d < r_row[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_row) begin
            r_used <= '0;
        end else if (i_cmd.ins) begin
            r_used <= {r_used[MaxNodes-2:0], 1'b1};
        end else if (i_cmd.shift_out) begin
            r_used <= {1'b0, r_used[MaxNodes-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MaxNodes; k++) begin
            if (i_cmd.ins) begin
                if (k == 0) begin
                    if (w_gt[0]) r_row[0] <= r_d;
                end else if (w_gt[k]) begin
                    r_row[k] <= w_gt[k-1] ? r_row[k-1] : r_d;
                end
            end else if (i_cmd.shift_out && k < MaxNodes - 1) begin
                r_row[k] <= r_row[k+1];
            end
        end
    end

    assign o_sts.total = r_total;
    assign o_head      = r_row[0];
endmodule

// ===== sv/wsd_ctrl.sv =====
module wsd_ctrl import wsd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in             i_item,
    input  t_sts            i_sts,
    input  logic            i_out_free,
    output t_cmd            o_cmd,
    output logic [IdxW-1:0] o_scan_idx,
    output logic            o_push,
    output logic [1:0]      o_status,
    output logic            o_dist,
    output logic [5:0]      o_rank,
    output logic            o_last
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LOAD = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;    // nodes read / results sent
    logic [CntW-1:0] r_n;
    logic [3:0]      r_pipe;          // read, calc, mult, insert stages
    logic            w_acc;

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign w_acc   = i_valid && o_ready;
    assign o_scan_idx = r_cnt[IdxW-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_push  = 1'b0;
        o_status = ST_DIST;
        o_dist   = 1'b0;
        o_last   = 1'b1;
        o_rank   = 6'(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_push = 1'b1;
                    if (i_item.command == CMD_ADD) begin
                        if (i_sts.total >= CntW'(MaxNodes)) begin
                            o_status = ST_FULL;
                        end else begin
                            o_status = ST_ADDED;
                            o_cmd.add_node = 1'b1;
                        end
                    end else if (i_sts.total == '0) begin
                        o_status = ST_EMPTY;
                    end else begin
                        o_push = 1'b0;
                        o_cmd.capture = 1'b1;
                        o_cmd.clr_row = 1'b1;
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt != r_n) begin
                    o_cmd.rd_node = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else if (r_pipe == '0) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end
            end
            S_LOAD: n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) begin
                    o_push = 1'b1;
                    o_dist = 1'b1;
                    o_last = (r_cnt + 1'b1 == r_n);
                    o_cmd.shift_out = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (o_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.calc = r_pipe[0];
        o_cmd.ins  = r_pipe[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pipe  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pipe  <= {r_pipe[2:0], o_cmd.rd_node};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_n <= i_sts.total;
    end
endmodule

// ===== sv/worley_sorted_distances.sv =====
// An add or an empty query is answered by a result registered at acceptance and
// presented in the next cycle. A query with N nodes reads the N nodes, lets the
// read, calc, mult and insert pipeline drain, then sends N results, one per cycle
// when output is taken.
// Sort cost is set by the single node-table read port, one node per cycle.
// Reset (i_rst_n low, synchronous) empties node table count and output.
module worley_sorted_distances import wsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [IdxW-1:0]  w_idx;
    logic [DistW-1:0] w_head;
    logic             w_push, w_dist, w_last, w_free;
    logic [1:0]       w_status;
    logic [5:0]       w_rank;
    logic             r_valid;
    t_out             r_data;

    // output register: free when empty or being taken this cycle
    assign w_free = !r_valid || i_ready;

    wsd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_data), .i_sts(w_sts), .i_out_free(w_free), .o_cmd(w_cmd),
        .o_scan_idx(w_idx), .o_push(w_push), .o_status(w_status),
        .o_dist(w_dist), .o_rank(w_rank), .o_last(w_last));

    wsd_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(i_data),
        .i_scan_idx(w_idx), .o_sts(w_sts), .o_head(w_head));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data.status      <= w_status;
            r_data.sq_distance <= w_dist ? w_head : '0;
            r_data.rank        <= w_dist ? w_rank : '0;
            r_data.last        <= w_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_free) else $error("beat pushed over unsent beat");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");
    a_nodist_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_DIST |-> o_data.rank == '0 && o_data.last)
        else $error("status beat with rank or not last");
endmodule

// ===== tb/tb_worley_sorted_distances.sv =====
`timescale 1ns / 1ps

module tb_worley_sorted_distances;
    import wsd_pkg::*;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // Input-side handshake
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;

    // Output-side handshake
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    worley_sorted_distances u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Stimulus waiting to be driven, and results the block owes us.
    t_in  cmd_queue[$];
    t_out owed_results[$];

    // Shadow copy of the feature table, updated as beats are accepted.
    logic [15:0] shadow_x[MaxNodes];
    logic [15:0] shadow_y[MaxNodes];
    int          shadow_total = 0;

    int  mismatches = 0;
    bit  stim_done = 1'b0;
    bit  calm_phase = 1'b0;   // last stretch: no idling on either side
    bit  hold_sink = 1'b0;    // long receiver hold-off request
    longint cycle_count = 0;

    // Compute what one accepted beat must produce and append to owed_results.
    task automatic predict_beat(input t_in beat);
        logic [DistW-1:0] dist_row[MaxNodes];
        logic [DistW-1:0] d;
        logic [16:0]      dx, dy;
        t_out             r;
        int               pos;
        if (beat.command == CMD_ADD) begin
            r = '0;
            r.last = 1'b1;
            if (shadow_total >= MaxNodes) begin
                r.status = ST_FULL;
            end else begin
                shadow_x[shadow_total] = beat.coord_x;
                shadow_y[shadow_total] = beat.coord_y;
                shadow_total++;
                r.status = ST_ADDED;
            end
            owed_results.push_back(r);
        end else if (shadow_total == 0) begin
            r = '0;
            r.status = ST_EMPTY;
            r.last = 1'b1;
            owed_results.push_back(r);
        end else begin
            // insertion sort of squared distances; ties keep arrival order
            for (int m = 0; m < shadow_total; m++) begin
                dx = (shadow_x[m] >= beat.coord_x) ? shadow_x[m] - beat.coord_x
                                                   : beat.coord_x - shadow_x[m];
                dy = (shadow_y[m] >= beat.coord_y) ? shadow_y[m] - beat.coord_y
                                                   : beat.coord_y - shadow_y[m];
                d = DistW'(dx[15:0]) * DistW'(dx[15:0])
                  + DistW'(dy[15:0]) * DistW'(dy[15:0]);
                pos = m;
                while (pos > 0 && d < dist_row[pos-1]) begin
                    dist_row[pos] = dist_row[pos-1];
                    pos--;
                end
                dist_row[pos] = d;
            end
            for (int m = 0; m < shadow_total; m++) begin
                r = '0;
                r.status = ST_DIST;
                r.sq_distance = dist_row[m];
                r.rank = 6'(m);
                r.last = (m == shadow_total - 1);
                owed_results.push_back(r);
            end
        end
    endtask

    function automatic t_in mk_item(logic c, logic [15:0] x, logic [15:0] y);
        t_in t;
        t.command = c;
        t.coord_x = x;
        t.coord_y = y;
        return t;
    endfunction

    // Random coordinate biased toward corners so the extreme bits toggle often.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(($urandom_range(0, 15)));
            3: return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: offers the next queued beat; random gap bursts between beats.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            // current beat (if any) accepted at this edge, or slot is empty
            if (i_valid)
                predict_beat(i_data);
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                i_data  <= cmd_queue.pop_front();
                i_valid <= 1'b1;
                if (!calm_phase && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 19);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver ready pattern: random stall bursts, plus one long hold-off.
    int sink_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_sink) begin
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 9) == 0)
                sink_gap <= $urandom_range(1, 19);
        end
    end

    // Monitor: compare every accepted result beat against the oldest owed one.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", o_data);
            end else begin
                want = owed_results.pop_front();
                if (o_data.status !== want.status
                        || o_data.sq_distance !== want.sq_distance
                        || o_data.rank !== want.rank
                        || o_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, o_data);
                end
            end
        end
    end

    // Watchdog on total run length: far above full-table queries under
    // maximal receiver stalls on every beat.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || i_valid || owed_results.size() > 0)
            @(posedge i_clk);
    endtask

    int n_rand;
    int hold_cycles;
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: query empty, one node, extremes and ties.
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'h0000, 16'h0000));
        cmd_queue.push_back(mk_item(CMD_ADD,   16'hFFFF, 16'hFFFF));
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'h0000, 16'h0000));
        cmd_queue.push_back(mk_item(CMD_ADD,   16'h0000, 16'h0000));
        cmd_queue.push_back(mk_item(CMD_ADD,   16'h0000, 16'hFFFF));
        cmd_queue.push_back(mk_item(CMD_ADD,   16'hFFFF, 16'h0000));
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'h8000, 16'h8000));
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'hFFFF, 16'hFFFF));
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'h0000, 16'hFFFF));
        cmd_queue.push_back(mk_item(CMD_ADD,   16'h8000, 16'h8000));
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'h5555, 16'hAAAA));
        wait_drained();

        // Long receiver hold-off while the sender keeps offering queries.
        for (int k = 0; k < 6; k++)
            cmd_queue.push_back(mk_item(CMD_QUERY, rand_coord(), rand_coord()));
        hold_sink = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        hold_sink = 1'b0;
        wait_drained();

        // Random: mostly adds until full, interleaved queries, then overflow.
        n_rand = 0;
        while (n_rand < 300) begin
            if (n_rand > 250)
                calm_phase = 1'b1;
            if (shadow_total + cmd_queue.size() < MaxNodes + 4
                    && $urandom_range(0, 2) != 0)
                cmd_queue.push_back(mk_item(CMD_ADD, rand_coord(), rand_coord()));
            else
                cmd_queue.push_back(mk_item(CMD_QUERY, rand_coord(), rand_coord()));
            n_rand++;
            if (cmd_queue.size() > 8)
                @(posedge i_clk);
        end
        // Make sure full-table adds and a full-size query both happen.
        cmd_queue.push_back(mk_item(CMD_ADD, 16'h1234, 16'h4321));
        cmd_queue.push_back(mk_item(CMD_QUERY, 16'hFFFF, 16'h0000));
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
